FILE: design/gdap_pkg.sv
// ----------------------------------------------------------------------------
// gdap_pkg - shared definitions for the graph diameter unit
// Field widths and the reset value of the city count register.
// ----------------------------------------------------------------------------
package gdap_pkg;

  localparam int COST_W  = 29;
  localparam int CITY_W  = 6;
  localparam int PRICE_W = 16;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

endpackage

FILE: design/gdap_cost_ram.sv
// ----------------------------------------------------------------------------
// gdap_cost_ram - cost matrix storage
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module gdap_cost_ram
  import gdap_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [COST_W-1:0] wdata,
  input  logic [AW-1:0]     ra_addr,
  input  logic [AW-1:0]     rb_addr,
  output logic [COST_W-1:0] ra_data,
  output logic [COST_W-1:0] rb_data
);

  logic [COST_W-1:0] mem [2**AW];

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

FILE: design/gdap_relax.sv
// ----------------------------------------------------------------------------
// gdap_relax - shared relaxation unit
// Saturating add of the two half-path costs, then compare with the entry.
// ----------------------------------------------------------------------------
module gdap_relax
  import gdap_pkg::*;
#(
  parameter int          AW            = 12,
  parameter int unsigned NO_ROUTE_COST = 288000000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld,
  input  logic [COST_W-1:0] pivot,
  input  logic [COST_W-1:0] far,
  input  logic [COST_W-1:0] cur,
  input  logic [AW-1:0]     addr,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [COST_W-1:0] wdata
);

  localparam logic [COST_W:0] NO_ROUTE_W = (COST_W + 1)'(NO_ROUTE_COST);

  logic [COST_W:0]   sum;
  logic [COST_W-1:0] via_nxt;
  logic [COST_W-1:0] via_r;
  logic [COST_W-1:0] cur_r;
  logic [AW-1:0]     addr_r;
  logic              vld_r;

  always_comb begin
    sum     = {1'b0, pivot} + {1'b0, far};
    via_nxt = (sum > NO_ROUTE_W) ? NO_ROUTE_W[COST_W-1:0] : sum[COST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld;
    end
    via_r  <= via_nxt;
    cur_r  <= cur;
    addr_r <= addr;
  end

  assign we    = vld_r && (via_r < cur_r);
  assign waddr = addr_r;
  assign wdata = via_r;

endmodule

FILE: design/graph_diameter_all_pairs_unit.sv
// ----------------------------------------------------------------------------
// graph_diameter_all_pairs_unit - all-pairs shortest path graph diameter
// Loads undirected edge records into a cost matrix, runs Floyd-Warshall on
// a shared relaxation unit after the last record and reports the diameter.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | transaction carries
//   --------+-----------+--------------------+------------------------------
//   in_     | input     | in_valid/in_stall  | has_edge, city_a/b, price, last
//   out_    | output    | out_valid/out_stall| diameter, disconnected
//   cfg_    | input     | cfg_valid/cfg_ready| city_count (always ready)
//
// A record that names two cities in use is written twice, since both mirror
// entries go through the single write port of the matrix. After the last
// record the block runs the relaxations (per row: a pivot read, n entries,
// then a drain of the relax unit), then sweeps the whole 2**(2*CW) entry
// matrix (4096 at 64 cities) to take the maximum and restore it, and then
// hands the result to the output register. After reset the same sweep
// clears the matrix with in_stall high. A result held by out_stall blocks
// only the next result; records are taken meanwhile.
// ----------------------------------------------------------------------------
module graph_diameter_all_pairs_unit
  import gdap_pkg::*;
#(
  parameter int          MAX_CITIES    = 64,
  parameter int unsigned NO_ROUTE_COST = 288000000
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_has_edge,
  input  logic [CITY_W-1:0]  in_city_a,
  input  logic [CITY_W-1:0]  in_city_b,
  input  logic [PRICE_W-1:0] in_price,
  input  logic               in_last,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [COST_W-1:0]  out_diameter,
  output logic               out_disconnected,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_city_count
);

  // Matrix entries are addressed as {row, column}, CW bits each.
  localparam int CW = $clog2(MAX_CITIES);
  localparam int AW = 2 * CW;
  localparam logic [COST_W-1:0] NO_ROUTE = COST_W'(NO_ROUTE_COST);

  typedef enum logic [3:0] {
    S_CLEAR,   // clearing sweep after reset
    S_IDLE,    // taking records
    S_MIRROR,  // second write of an edge record
    S_PIVOT,   // read the pivot entry m[i][k] of a row
    S_ROW,     // issue the reads of m[i][j] and m[k][j]
    S_DRAIN,   // let the relax unit finish its last writes
    S_SWEEP,   // find the maximum and restore the matrix
    S_TAIL,    // last sweep read lands
    S_RESULT   // hand the result to the output register
  } state_t;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] city_count_r, city_count_nxt;
  logic [CW-1:0]      k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [COST_W-1:0]  p_r, p_nxt;
  logic               last_r, last_nxt;
  logic [COST_W-1:0]  pivot_r, pivot_nxt;
  logic               pivot_cap_r, pivot_cap_nxt;
  logic               v1_r, v1_nxt;
  logic [AW-1:0]      addr1_r, addr1_nxt;
  logic               drain_r, drain_nxt;
  logic [AW-1:0]      s_r, s_nxt;
  logic               sv_r, sv_nxt;
  logic               sin_r, sin_nxt;
  logic [COST_W-1:0]  best_r, best_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COST_W-1:0]  out_diam_r, out_diam_nxt;
  logic               out_disc_r, out_disc_nxt;

  // Cities in use, with zero read as one and the count capped at the matrix size.
  int unsigned        n_int;
  logic [CW:0]        n_w;
  logic [CW-1:0]      n_m1;
  logic               in_accept;
  logic               edge_ok;
  logic [COST_W-1:0]  price_sat;
  logic [CW-1:0]      in_a_idx, in_b_idx;
  logic               sweep_in;
  logic [COST_W-1:0]  clear_val;
  logic               slot_free;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COST_W-1:0]  mem_wdata;
  logic [AW-1:0]      ra_addr, rb_addr;
  logic [COST_W-1:0]  ra_data, rb_data;

  logic               rx_we;
  logic [AW-1:0]      rx_waddr;
  logic [COST_W-1:0]  rx_wdata;

  always_comb begin
    if (city_count_r == '0) begin
      n_int = 1;
    end else if (int'(city_count_r) > MAX_CITIES) begin
      n_int = MAX_CITIES;
    end else begin
      n_int = int'(city_count_r);
    end
    n_w  = (CW + 1)'(n_int);
    n_m1 = CW'(n_w - (CW + 1)'(1));
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign edge_ok   = in_has_edge && (32'(in_city_a) < 32'(n_w))
                     && (32'(in_city_b) < 32'(n_w));
  assign in_a_idx  = CW'(in_city_a);
  assign in_b_idx  = CW'(in_city_b);
  assign price_sat = (COST_W'(in_price) > NO_ROUTE) ? NO_ROUTE : COST_W'(in_price);

  // Sweep position split into row and column.
  assign sweep_in  = ({1'b0, s_r[AW-1:CW]} < n_w) && ({1'b0, s_r[CW-1:0]} < n_w);
  assign clear_val = (s_r[AW-1:CW] == s_r[CW-1:0]) ? '0 : NO_ROUTE;
  assign slot_free = !out_valid_r || !out_stall;

  // Write port: record loads, mirror writes, sweep restores and relaxations
  // never overlap, since each belongs to its own state.
  always_comb begin
    mem_we    = rx_we;
    mem_waddr = rx_waddr;
    mem_wdata = rx_wdata;
    unique case (state_r) inside
      S_IDLE: begin
        mem_we    = in_accept && edge_ok;
        mem_waddr = {in_a_idx, in_b_idx};
        mem_wdata = price_sat;
      end
      S_MIRROR: begin
        mem_we    = 1'b1;
        mem_waddr = {b_r, a_r};
        mem_wdata = p_r;
      end
      S_CLEAR, S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = s_r;
        mem_wdata = clear_val;
      end
      default: ;
    endcase
  end

  always_comb begin
    ra_addr = {i_r, j_r};
    unique case (state_r) inside
      S_PIVOT:          ra_addr = {i_r, k_r};
      S_SWEEP, S_CLEAR: ra_addr = s_r;
      default:          ra_addr = {i_r, j_r};
    endcase
    rb_addr = {k_r, j_r};
  end

  gdap_cost_ram #(
    .AW (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // One relaxation per cycle while a row is issued: m[i][j] = min(m[i][j], m[i][k] + m[k][j]).
  gdap_relax #(
    .AW            (AW),
    .NO_ROUTE_COST (NO_ROUTE_COST)
  ) u_relax (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (v1_r),
    .pivot (pivot_r),
    .far   (rb_data),
    .cur   (ra_data),
    .addr  (addr1_r),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata)
  );

  always_comb begin
    state_nxt      = state_r;
    city_count_nxt = cfg_valid ? cfg_city_count : city_count_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    p_nxt          = p_r;
    last_nxt       = last_r;
    pivot_nxt      = pivot_cap_r ? ra_data : pivot_r;
    pivot_cap_nxt  = (state_r == S_PIVOT);
    v1_nxt         = (state_r == S_ROW);
    addr1_nxt      = {i_r, j_r};
    drain_nxt      = drain_r;
    s_nxt          = s_r;
    sv_nxt         = (state_r == S_SWEEP);
    sin_nxt        = sweep_in;
    best_nxt       = (sv_r && sin_r && (ra_data > best_r)) ? ra_data : best_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_diam_nxt   = out_diam_r;
    out_disc_nxt   = out_disc_r;

    unique case (state_r)
      S_CLEAR: begin
        s_nxt = s_r + AW'(1);
        if (s_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          a_nxt    = in_a_idx;
          b_nxt    = in_b_idx;
          p_nxt    = price_sat;
          last_nxt = in_last;
          k_nxt    = '0;
          i_nxt    = '0;
          if (edge_ok) begin
            state_nxt = S_MIRROR;
          end else if (in_last) begin
            state_nxt = S_PIVOT;
          end
        end
      end
      S_MIRROR: begin
        state_nxt = last_r ? S_PIVOT : S_IDLE;
      end
      S_PIVOT: begin
        j_nxt     = '0;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        if (j_r == n_m1) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          if (i_r != n_m1) begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_PIVOT;
          end else if (k_r != n_m1) begin
            i_nxt     = '0;
            k_nxt     = k_r + CW'(1);
            state_nxt = S_PIVOT;
          end else begin
            s_nxt     = '0;
            best_nxt  = '0;
            state_nxt = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        s_nxt = s_r + AW'(1);
        if (s_r == '1) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_diam_nxt  = best_r;
          out_disc_nxt  = (best_r >= NO_ROUTE);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      city_count_r <= COUNT_RESET;
      s_r          <= '0;
      pivot_cap_r  <= 1'b0;
      v1_r         <= 1'b0;
      drain_r      <= 1'b0;
      sv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      city_count_r <= city_count_nxt;
      s_r          <= s_nxt;
      pivot_cap_r  <= pivot_cap_nxt;
      v1_r         <= v1_nxt;
      drain_r      <= drain_nxt;
      sv_r         <= sv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    p_r        <= p_nxt;
    last_r     <= last_nxt;
    pivot_r    <= pivot_nxt;
    addr1_r    <= addr1_nxt;
    sin_r      <= sin_nxt;
    best_r     <= best_nxt;
    out_diam_r <= out_diam_nxt;
    out_disc_r <= out_disc_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_diameter     = out_diam_r;
  assign out_disconnected = out_disc_r;

endmodule

FILE: design/gdap_checker.sv
// ----------------------------------------------------------------------------
// gdap_checker - port-level checks for the graph diameter unit
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module gdap_checker
  import gdap_pkg::*;
#(
  parameter int unsigned NO_ROUTE_COST = 288000000
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_stall,
  input logic [COST_W-1:0] out_diameter,
  input logic              out_disconnected
);

  localparam logic [COST_W-1:0] NO_ROUTE = COST_W'(NO_ROUTE_COST);

  // A result held by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_diameter)
                               && $stable(out_disconnected))
    else $error("result changed while stalled");

  // The flag marks exactly the no-route diameter.
  a_disc_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_disconnected == (out_diameter == NO_ROUTE)))
    else $error("disconnected flag disagrees with diameter");

  // No diameter exceeds the no-route cost.
  a_diam_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_diameter <= NO_ROUTE))
    else $error("diameter above no-route cost");

  // The last record starts the computation, so no record follows at once.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("record taken right after the last one");

  // The matrix clearing sweep follows reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_stall)
    else $error("record taken during the clearing sweep");

endmodule

bind graph_diameter_all_pairs_unit gdap_checker #(
  .NO_ROUTE_COST (NO_ROUTE_COST)
) u_gdap_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_diameter     (out_diameter),
  .out_disconnected (out_disconnected)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the graph diameter unit
// Sends sets of edge records, each closed by a last record, and checks every
// reported diameter and disconnected flag against an in-bench shortest path
// predictor while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
  import gdap_pkg::*;
();

  localparam int          CITY_MAX    = 64;
  localparam int unsigned NO_ROUTE    = 288000000;
  localparam int          MAX_REPORTS = 10;

  // One input transaction and one result transaction.
  typedef struct packed {
    logic               has_edge;
    logic [CITY_W-1:0]  city_a;
    logic [CITY_W-1:0]  city_b;
    logic [PRICE_W-1:0] price;
    logic               last;
  } edge_rec_t;

  typedef struct packed {
    logic [COST_W-1:0] diameter;
    logic              disconnected;
  } span_t;

  // Receiver behavior: no stalls, occasional stalls or mostly stalled.
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic               in_has_edge      = 1'b0;
  logic [CITY_W-1:0]  in_city_a        = '0;
  logic [CITY_W-1:0]  in_city_b        = '0;
  logic [PRICE_W-1:0] in_price         = '0;
  logic               in_last          = 1'b0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [COST_W-1:0]  out_diameter;
  logic               out_disconnected;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_city_count   = '0;

  // Predictor state: its own copy of the cost matrix and the city count.
  int unsigned        route_cost [CITY_MAX][CITY_MAX];
  logic [COUNT_W-1:0] city_count_q;

  // Diameters still owed by the block, oldest first.
  span_t span_q[$];

  int mismatches  = 0;
  int burst_left  = 0;
  // A long receiver hold-off asked for by a test, picked up by the stall process.
  int hold_req    = 0;

  graph_diameter_all_pairs_unit #(
    .MAX_CITIES    (CITY_MAX),
    .NO_ROUTE_COST (NO_ROUTE)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_has_edge      (in_has_edge),
    .in_city_a        (in_city_a),
    .in_city_b        (in_city_b),
    .in_price         (in_price),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_diameter     (out_diameter),
    .out_disconnected (out_disconnected),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_city_count   (cfg_city_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The time-out bound leaves room for the longest correct run, which
  // includes the two 64-city relaxations.
  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A count of zero behaves as one city, anything past the matrix as all.
  function automatic int unsigned cities_in_use();
    int unsigned n;
    n = 32'(city_count_q);
    if (n == 0) n = 1;
    if (n > CITY_MAX) n = CITY_MAX;
    return n;
  endfunction

  function automatic void clear_costs();
    for (int i = 0; i < CITY_MAX; i++)
      for (int j = 0; j < CITY_MAX; j++)
        route_cost[i][j] = (i == j) ? 0 : NO_ROUTE;
  endfunction

  // Floyd-Warshall over the cities in use with sums clipped at the no-route
  // cost, then the largest entry, diagonal included. The matrix is emptied
  // afterwards, as the block does after each result.
  function automatic span_t all_pairs_diameter(input int unsigned n);
    int unsigned via;
    int unsigned best;
    span_t       span;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          via = route_cost[i][k] + route_cost[k][j];
          if (via > NO_ROUTE) via = NO_ROUTE;
          if (via < route_cost[i][j]) route_cost[i][j] = via;
        end
    best = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (route_cost[i][j] > best) best = route_cost[i][j];
    span.diameter     = best[COST_W-1:0];
    span.disconnected = (best >= NO_ROUTE);
    clear_costs();
    return span;
  endfunction

  // Applies one accepted record; a last record owes one diameter.
  function automatic void predict_record(input edge_rec_t rec);
    int unsigned n;
    int unsigned p;
    n = cities_in_use();
    if (rec.has_edge && 32'(rec.city_a) < n && 32'(rec.city_b) < n) begin
      p = 32'(rec.price);
      if (p > NO_ROUTE) p = NO_ROUTE;
      route_cost[rec.city_a][rec.city_b] = p;
      route_cost[rec.city_b][rec.city_a] = p;
    end
    if (rec.last) span_q.push_back(all_pairs_diameter(n));
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every accepted result transaction is matched against
  // the oldest owed diameter. Failures are counted and the run goes on.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    span_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (span_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with nothing pending: diameter %0d disconnected %0b",
                   out_diameter, out_disconnected);
      end else begin
        want = span_q.pop_front();
        if (out_diameter !== want.diameter || out_disconnected !== want.disconnected) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: diameter exp %0d got %0d, disconnected exp %0b got %0b",
                     want.diameter, out_diameter, want.disconnected, out_disconnected);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stalls. The pattern switches between segments with no stalls,
  // light stalls and heavy stalls, so stall gaps land on every phase of the
  // block's work. A requested hold-off overrides it and is counted down here.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          seg_left   = 0;
  int          hold_left  = 0;

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (seg_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      seg_left   = $urandom_range(16, 300);
    end
    seg_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  function automatic edge_rec_t make_record(input logic has_edge, input int a, input int b,
                                            input int price, input logic last);
    edge_rec_t rec;
    rec.has_edge = has_edge;
    rec.city_a   = CITY_W'(a);
    rec.city_b   = CITY_W'(b);
    rec.price    = PRICE_W'(price);
    rec.last     = last;
    return rec;
  endfunction

  // Offers one record and waits for its transaction. Records go out in
  // bursts of random length; between bursts valid drops for a random gap,
  // which is sometimes zero so that long unbroken stretches occur as well.
  // Valid stays high after the transaction so a following record in the
  // same burst goes out on the next edge.
  task automatic send_record(input edge_rec_t rec);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 30);
      else gap = $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_has_edge <= rec.has_edge;
    in_city_a   <= rec.city_a;
    in_city_b   <= rec.city_b;
    in_price    <= rec.price;
    in_last     <= rec.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_record(rec);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Always waits for a clock edge before it returns, so valid is never
  // dropped and raised again within one time step.
  task automatic wait_drained();
    do @(posedge clk); while (span_q.size() != 0);
  endtask

  // The city count is only changed with the block idle: every owed result
  // has arrived, and an extra wait covers a trailing non-last record.
  task automatic write_city_count(input int value);
    stop_sending();
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_city_count <= COUNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    city_count_q = COUNT_W'(value);
    cfg_valid <= 1'b0;
  endtask

  function automatic int road_price(input bit cheap);
    return cheap ? $urandom_range(0, 15) : $urandom_range(0, 65535);
  endfunction

  // Builds one set of records for the current city count. Most sets link
  // every city through a random tree so the diameter is a real path cost;
  // the rest are left sparse. Extra edges, self-loops, bare records and
  // records naming cities out of use are mixed in at random positions.
  function automatic void build_random_set(ref edge_rec_t trip[$]);
    int unsigned n;
    bit          cheap;
    bit          linked;
    int          extra;
    int          kind;
    int          a;
    int          b;
    int          t;
    edge_rec_t   rec;
    trip.delete();
    n      = cities_in_use();
    cheap  = ($urandom_range(0, 3) == 0);
    linked = ($urandom_range(0, 3) != 0);
    if (linked) begin
      for (int c = 1; c < n; c++) begin
        b = $urandom_range(0, c - 1);
        if ($urandom_range(0, 1)) trip.push_back(make_record(1'b1, c, b, road_price(cheap), 1'b0));
        else trip.push_back(make_record(1'b1, b, c, road_price(cheap), 1'b0));
      end
    end
    extra = $urandom_range(0, 3 * n + 4);
    repeat (extra) begin
      kind = $urandom_range(0, 9);
      a    = $urandom_range(0, n - 1);
      b    = $urandom_range(0, n - 1);
      if (kind == 0) begin
        rec = make_record(1'b0, $urandom_range(0, CITY_MAX - 1), $urandom_range(0, CITY_MAX - 1),
                          $urandom_range(0, 65535), 1'b0);
      end else begin
        if (kind == 1) begin
          a = (n < CITY_MAX) ? $urandom_range(n, CITY_MAX - 1) : $urandom_range(0, CITY_MAX - 1);
          b = $urandom_range(0, CITY_MAX - 1);
          if ($urandom_range(0, 1)) begin
            t = a;
            a = b;
            b = t;
          end
        end else if (kind == 2) begin
          b = a;
        end
        rec = make_record(1'b1, a, b, road_price(cheap), 1'b0);
      end
      trip.insert($urandom_range(0, trip.size()), rec);
    end
    if ($urandom_range(0, 1))
      rec = make_record(1'b0, $urandom_range(0, CITY_MAX - 1), $urandom_range(0, CITY_MAX - 1),
                        $urandom_range(0, 65535), 1'b1);
    else
      rec = make_record(1'b1, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                        road_price(cheap), 1'b1);
    trip.push_back(rec);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset value of the city count: all 64 cities, with the extreme city
  // indices and prices. Most pairs stay unreachable, so the set is flagged.
  task automatic test_reset_count();
    send_record(make_record(1'b1, 0, 63, 65535, 1'b0));
    send_record(make_record(1'b1, 63, 62, 0, 1'b0));
    send_record(make_record(1'b1, 5, 5, 40000, 1'b0));
    send_record(make_record(1'b0, 0, 0, 0, 1'b1));
  endtask

  // One city: a self-loop sets the only diagonal entry; a record naming a
  // second city is ignored. A count of zero must behave as one city.
  task automatic test_single_city();
    write_city_count(1);
    send_record(make_record(1'b1, 0, 0, 65535, 1'b1));
    send_record(make_record(1'b1, 0, 1, 7, 1'b1));
    write_city_count(0);
    send_record(make_record(1'b0, 0, 0, 0, 1'b1));
    send_record(make_record(1'b1, 0, 0, 3, 1'b0));
    send_record(make_record(1'b1, 0, 0, 9, 1'b1));
  endtask

  // Four cities: a later record for a pair overwrites the earlier one, a
  // self-loop above the cheapest closed walk, a bare record that does
  // nothing, an out-of-range record and a zero price on the last record.
  // Then two cities with no edge at all.
  task automatic test_small_graph();
    write_city_count(4);
    send_record(make_record(1'b1, 0, 1, 10, 1'b0));
    send_record(make_record(1'b1, 1, 2, 20, 1'b0));
    send_record(make_record(1'b1, 2, 3, 5, 1'b0));
    send_record(make_record(1'b1, 3, 0, 100, 1'b0));
    send_record(make_record(1'b1, 1, 0, 1, 1'b0));
    send_record(make_record(1'b1, 2, 2, 65535, 1'b0));
    send_record(make_record(1'b0, 3, 1, 2, 1'b0));
    send_record(make_record(1'b1, 0, 40, 0, 1'b0));
    send_record(make_record(1'b1, 1, 3, 0, 1'b1));
    write_city_count(2);
    send_record(make_record(1'b0, 1, 0, 0, 1'b1));
  endtask

  // A count above the matrix size acts as the full 64 cities.
  task automatic test_count_clamp();
    write_city_count(127);
    send_record(make_record(1'b1, 63, 0, 12345, 1'b0));
    send_record(make_record(1'b1, 62, 63, 0, 1'b1));
  endtask

  // The receiver holds off for a long stretch while several sets keep
  // coming, so one result waits, the next completes behind it and the
  // input has to stall. Then the sender waits for every result.
  task automatic test_backpressure();
    write_city_count(3);
    hold_req = 20000;
    repeat (5) begin
      send_record(make_record(1'b1, 0, 1, $urandom_range(0, 65535), 1'b0));
      send_record(make_record(1'b1, 2, 1, $urandom_range(0, 65535), 1'b0));
      send_record(make_record(1'b1, 0, 2, $urandom_range(0, 65535), 1'b1));
    end
    stop_sending();
    wait_drained();
  endtask

  // Random sets. City counts are mostly small since every result costs a
  // full matrix sweep; now and then a set uses up to 24 cities.
  task automatic test_random_sets(input int budget);
    edge_rec_t trip[$];
    int        sent;
    int        pick;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) write_city_count($urandom_range(1, 8));
        else if (pick < 9) write_city_count($urandom_range(9, 16));
        else write_city_count($urandom_range(17, 24));
      end
      build_random_set(trip);
      foreach (trip[i]) send_record(trip[i]);
      sent += trip.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    city_count_q = COUNT_RESET;
    clear_costs();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_count();
    test_single_city();
    test_small_graph();
    test_count_clamp();
    test_backpressure();
    test_random_sets(1650);

    stop_sending();
    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && span_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/gdap_pkg.sv
design/gdap_cost_ram.sv
design/gdap_relax.sv
design/graph_diameter_all_pairs_unit.sv
design/gdap_checker.sv
dv/tb_top.sv
